@@ rtl/nrsh_pkg.sv @@
package nrsh_pkg;

    localparam int COORD_W      = 32;
    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SEG_W        = 2 * COORD_W;

    // coordinate differences carry one extra bit, products of two of them
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int MAG_W  = ACC_W - 1;
    localparam int Q_W    = DIFF_W + 1;
    localparam int DIST_W = PROD_W + 1;

    localparam int SCNT_W  = 9;
    localparam int MDIST_W = 63;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic REG_SEG_COUNT = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

endpackage

@@ rtl/nearest_ray_segment_hit_top.sv @@
// channel   direction  handshake               payload
// command   in         start && !busy          func seg_index ax ay bx by
// result    out        done (one cycle)        hit hit_index hit_x hit_y
// config    in         psel penable pwrite     paddr pwdata (prdata back)
//
// A load is written at the edge that accepts it. With no segments, a query's
// result is on done in the cycle that starts at the accepting edge. Otherwise
// each segment takes six products on one shared 33x33 multiplier; one that passes
// the parallel, ahead and range tests goes on to the hit point through the serial
// scale-divide, one multiplier bit per cycle, and then two squares.
// Reset clears control and registers; the segment tables hold garbage until
// loaded. Results cannot be stalled; busy holds off new commands.
module nearest_ray_segment_hit_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [nrsh_pkg::ADDR_W-1:0]         seg_index,
    input  logic signed [nrsh_pkg::COORD_W-1:0] ax,
    input  logic signed [nrsh_pkg::COORD_W-1:0] ay,
    input  logic signed [nrsh_pkg::COORD_W-1:0] bx,
    input  logic signed [nrsh_pkg::COORD_W-1:0] by,
    output logic                                done,
    output logic                                hit,
    output logic [nrsh_pkg::ADDR_W-1:0]         hit_index,
    output logic signed [nrsh_pkg::COORD_W-1:0] hit_x,
    output logic signed [nrsh_pkg::COORD_W-1:0] hit_y,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nrsh_pkg::PADDR_W-1:0]        paddr,
    input  logic [nrsh_pkg::PDATA_W-1:0]        pwdata,
    output logic [nrsh_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import nrsh_pkg::*;

    typedef enum logic [3:0] {
        IDLE, READ, DIFF, MUL, TEST, DIV, SQ, CMP, NEXT
    } state_t;

    state_t state_reg;

    logic [SCNT_W-1:0]  seg_count_reg;
    logic [MDIST_W-1:0] max_dist_reg;

    logic signed [COORD_W-1:0] ox_reg, oy_reg, dx_reg, dy_reg;
    logic signed [COORD_W-1:0] sax_reg, say_reg;
    logic signed [DIFF_W-1:0]  sx_reg, sy_reg, aox_reg, aoy_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]   den_reg, tn_reg, un_reg;
    logic signed [COORD_W-1:0] hx_reg, hy_reg;
    logic [DIST_W-1:0]         dsum_reg, best_reg;
    logic                      found_reg;
    logic [ADDR_W-1:0]         best_idx_reg;
    logic signed [COORD_W-1:0] best_x_reg, best_y_reg;
    logic [CNT_W-1:0]          idx_reg, n_reg;
    logic [2:0]                mstep_reg;

    logic                      done_reg, hit_reg;
    logic [ADDR_W-1:0]         hit_index_reg;
    logic signed [COORD_W-1:0] hit_x_reg, hit_y_reg;

    logic              cmd_ok, load_we, cfg_we;
    logic [SEG_W-1:0]  start_rd, end_rd;
    logic [CNT_W-1:0]  n_next, idx_next;

    logic signed [DIFF_W-1:0] mul_a, mul_b, ex, ey;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  pe, den_n, tn_n, un_n;
    logic                     neg, skip;
    logic                     x_done, y_done;
    logic signed [Q_W:0]      qx, qy;
    logic signed [Q_W:0]      hx_sum, hy_sum;
    logic [DIST_W-1:0]        pu;

    assign cmd_ok  = start && (state_reg == IDLE);
    assign load_we = cmd_ok && (func == FUNC_LOAD);
    assign cfg_we  = psel && penable && pwrite;
    assign busy    = (state_reg != IDLE);
    assign pready  = 1'b1;
    assign prdata  = (paddr[3] == REG_MAX_DIST) ? {1'b0, max_dist_reg}
                                                : {{(PDATA_W-SCNT_W){1'b0}}, seg_count_reg};

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign hit_index = hit_index_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;

    nrsh_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_start_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (seg_index),
        .wdata ({ay, ax}),
        .re    (state_reg == READ),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (start_rd)
    );

    nrsh_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_end_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (seg_index),
        .wdata ({by, bx}),
        .re    (state_reg == READ),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (end_rd)
    );

    always_comb
    begin
        n_next   = (seg_count_reg > SCNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                           : CNT_W'(seg_count_reg);
        idx_next = idx_reg + 1'b1;

        ex = $signed({hx_reg[COORD_W-1], hx_reg}) - $signed({ox_reg[COORD_W-1], ox_reg});
        ey = $signed({hy_reg[COORD_W-1], hy_reg}) - $signed({oy_reg[COORD_W-1], oy_reg});

        mul_a = '0;
        mul_b = '0;
        if (state_reg == MUL)
        begin
            unique case (mstep_reg)
                3'd0:    begin mul_a = DIFF_W'(dx_reg); mul_b = sy_reg;  end
                3'd1:    begin mul_a = DIFF_W'(dy_reg); mul_b = sx_reg;  end
                3'd2:    begin mul_a = aox_reg;         mul_b = sy_reg;  end
                3'd3:    begin mul_a = aoy_reg;         mul_b = sx_reg;  end
                3'd4:    begin mul_a = DIFF_W'(dy_reg); mul_b = aox_reg; end
                3'd5:    begin mul_a = DIFF_W'(dx_reg); mul_b = aoy_reg; end
                default: begin mul_a = '0;              mul_b = '0;      end
            endcase
        end
        else if (state_reg == SQ)
        begin
            unique case (mstep_reg)
                3'd0:    begin mul_a = ex; mul_b = ex; end
                3'd1:    begin mul_a = ey; mul_b = ey; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        prod = mul_a * mul_b;
        pe   = ACC_W'(p_reg);
        pu   = {1'b0, p_reg};

        // orient so the denominator is positive
        neg   = den_reg[ACC_W-1];
        den_n = neg ? -den_reg : den_reg;
        tn_n  = neg ? -tn_reg  : tn_reg;
        un_n  = neg ? -un_reg  : un_reg;
        skip  = (den_reg == '0) || (tn_n <= 0) || (un_n < 0) || (un_n > den_n);

        hx_sum = $signed({{(Q_W+1-COORD_W){sax_reg[COORD_W-1]}}, sax_reg}) + qx;
        hy_sum = $signed({{(Q_W+1-COORD_W){say_reg[COORD_W-1]}}, say_reg}) + qy;
    end

    nrsh_scale u_scale_x (
        .clk   (clk),
        .rst_n (rst_n),
        .go    ((state_reg == TEST) && !skip),
        .m     (sx_reg),
        .num   (MAG_W'(un_n)),
        .den   (MAG_W'(den_n)),
        .done  (x_done),
        .q     (qx)
    );

    nrsh_scale u_scale_y (
        .clk   (clk),
        .rst_n (rst_n),
        .go    ((state_reg == TEST) && !skip),
        .m     (sy_reg),
        .num   (MAG_W'(un_n)),
        .den   (MAG_W'(den_n)),
        .done  (y_done),
        .q     (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            seg_count_reg <= '0;
            max_dist_reg  <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_index_reg <= '0;
            hit_x_reg     <= '0;
            hit_y_reg     <= '0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            mstep_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            p_reg    <= prod;

            if (cfg_we)
            begin
                if (paddr[3] == REG_SEG_COUNT)
                begin
                    seg_count_reg <= pwdata[SCNT_W-1:0];
                end
                else
                begin
                    max_dist_reg <= pwdata[MDIST_W-1:0];
                end
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (cmd_ok && (func == FUNC_QUERY))
                    begin
                        ox_reg    <= ax;
                        oy_reg    <= ay;
                        dx_reg    <= bx;
                        dy_reg    <= by;
                        best_reg  <= DIST_W'(max_dist_reg);
                        found_reg <= 1'b0;
                        idx_reg   <= '0;
                        n_reg     <= n_next;
                        if (n_next == '0)
                        begin
                            done_reg      <= 1'b1;
                            hit_reg       <= 1'b0;
                            hit_index_reg <= '0;
                            hit_x_reg     <= '0;
                            hit_y_reg     <= '0;
                        end
                        else
                        begin
                            state_reg <= READ;
                        end
                    end
                end
                READ:
                begin
                    state_reg <= DIFF;
                end
                DIFF:
                begin
                    sax_reg   <= start_rd[COORD_W-1:0];
                    say_reg   <= start_rd[SEG_W-1:COORD_W];
                    sx_reg    <= $signed({end_rd[COORD_W-1], end_rd[COORD_W-1:0]})
                               - $signed({start_rd[COORD_W-1], start_rd[COORD_W-1:0]});
                    sy_reg    <= $signed({end_rd[SEG_W-1], end_rd[SEG_W-1:COORD_W]})
                               - $signed({start_rd[SEG_W-1], start_rd[SEG_W-1:COORD_W]});
                    aox_reg   <= $signed({start_rd[COORD_W-1], start_rd[COORD_W-1:0]})
                               - $signed({ox_reg[COORD_W-1], ox_reg});
                    aoy_reg   <= $signed({start_rd[SEG_W-1], start_rd[SEG_W-1:COORD_W]})
                               - $signed({oy_reg[COORD_W-1], oy_reg});
                    mstep_reg <= '0;
                    state_reg <= MUL;
                end
                MUL:
                begin
                    // accumulate the product issued one step earlier
                    unique case (mstep_reg)
                        3'd1:    den_reg <= pe;
                        3'd2:    den_reg <= den_reg - pe;
                        3'd3:    tn_reg  <= pe;
                        3'd4:    tn_reg  <= tn_reg - pe;
                        3'd5:    un_reg  <= pe;
                        3'd6:    un_reg  <= un_reg - pe;
                        default: ;
                    endcase
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 3'd6)
                    begin
                        state_reg <= TEST;
                    end
                end
                TEST:
                begin
                    state_reg <= skip ? NEXT : DIV;
                end
                DIV:
                begin
                    if (x_done && y_done)
                    begin
                        hx_reg    <= hx_sum[COORD_W-1:0];
                        hy_reg    <= hy_sum[COORD_W-1:0];
                        mstep_reg <= '0;
                        state_reg <= SQ;
                    end
                end
                SQ:
                begin
                    unique case (mstep_reg)
                        3'd1:    dsum_reg <= pu;
                        3'd2:    dsum_reg <= dsum_reg + pu;
                        default: ;
                    endcase
                    mstep_reg <= mstep_reg + 1'b1;
                    if (mstep_reg == 3'd2)
                    begin
                        state_reg <= CMP;
                    end
                end
                CMP:
                begin
                    if ((dsum_reg != '0) && (dsum_reg < best_reg))
                    begin
                        best_reg     <= dsum_reg;
                        found_reg    <= 1'b1;
                        best_idx_reg <= idx_reg[ADDR_W-1:0];
                        best_x_reg   <= hx_reg;
                        best_y_reg   <= hy_reg;
                    end
                    state_reg <= NEXT;
                end
                NEXT:
                begin
                    if (idx_next == n_reg)
                    begin
                        done_reg      <= 1'b1;
                        hit_reg       <= found_reg;
                        hit_index_reg <= found_reg ? best_idx_reg : '0;
                        hit_x_reg     <= found_reg ? best_x_reg : '0;
                        hit_y_reg     <= found_reg ? best_y_reg : '0;
                        state_reg     <= IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_next;
                        state_reg <= READ;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/nrsh_ram.sv @@
module nrsh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/nrsh_scale.sv @@
// floor(m * num / den) for 0 <= num <= den, one multiplier bit per cycle
module nrsh_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic signed [nrsh_pkg::DIFF_W-1:0]   m,
    input  logic        [nrsh_pkg::MAG_W-1:0]    num,
    input  logic        [nrsh_pkg::MAG_W-1:0]    den,
    output logic                                 done,
    output logic signed [nrsh_pkg::Q_W:0]        q
);
    import nrsh_pkg::*;

    localparam int STEPS = DIFF_W;
    localparam int SC_W  = $clog2(STEPS);
    localparam logic [SC_W-1:0] LAST = SC_W'(STEPS - 1);

    logic              run_reg;
    logic              done_reg;
    logic [SC_W-1:0]   cnt_reg;
    logic              neg_reg;
    logic [DIFF_W-1:0] mag_reg;
    logic [MAG_W-1:0]  num_reg;
    logic [MAG_W-1:0]  den_reg;
    logic [MAG_W-1:0]  r_reg;
    logic [Q_W-1:0]    q_reg;

    logic [MAG_W+1:0]  r2;
    logic [MAG_W+1:0]  den1;
    logic [MAG_W+1:0]  den2;
    logic [MAG_W-1:0]  r_next;
    logic [1:0]        qadd;
    logic [Q_W-1:0]    q_next;
    logic [Q_W:0]      qe;
    logic [Q_W:0]      rnd;

    always_comb
    begin
        r2   = {1'b0, r_reg, 1'b0} + (mag_reg[DIFF_W-1] ? {2'b0, num_reg} : '0);
        den1 = {2'b0, den_reg};
        den2 = {1'b0, den_reg, 1'b0};
        priority if (r2 >= den2)
        begin
            r_next = MAG_W'(r2 - den2);
            qadd   = 2'd2;
        end
        else if (r2 >= den1)
        begin
            r_next = MAG_W'(r2 - den1);
            qadd   = 2'd1;
        end
        else
        begin
            r_next = MAG_W'(r2);
            qadd   = 2'd0;
        end
        q_next = {q_reg[Q_W-2:0], 1'b0} + {{(Q_W-2){1'b0}}, qadd};
        qe     = {1'b0, q_reg};
        rnd    = {{Q_W{1'b0}}, (r_reg != '0)};
        q      = neg_reg ? $signed(-(qe + rnd)) : $signed(qe);
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                neg_reg <= m[DIFF_W-1];
                mag_reg <= m[DIFF_W-1] ? DIFF_W'(-m) : DIFF_W'(m);
                num_reg <= num;
                den_reg <= den;
                r_reg   <= '0;
                q_reg   <= '0;
            end
            else if (run_reg)
            begin
                r_reg   <= r_next;
                q_reg   <= q_next;
                mag_reg <= {mag_reg[DIFF_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import nrsh_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint NEAR = 64'sd268435456;     // keep random geometry within +-2^28
    localparam logic [62:0] DIST_MAX = {63{1'b1}};

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic        hit;
        logic [7:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
    } hit_result_t;

    class hit_scoreboard;
        logic [31:0] start_x[MAX_SEGMENTS], start_y[MAX_SEGMENTS];
        logic [31:0] end_x[MAX_SEGMENTS], end_y[MAX_SEGMENTS];
        logic [8:0]  seg_count;
        logic [62:0] dist_limit;
        hit_result_t expected_hits[$];
        int errors, loads, queries, hits, results;

        function new();
            seg_count = '0;
            dist_limit = '0;
            errors = 0; loads = 0; queries = 0; hits = 0; results = 0;
        endfunction

        function hit_result_t nearest_hit(longint ox, longint oy, longint dx, longint dy);
            hit_result_t r;
            wide_t best, den, tn, xn, yn, d, q, hx, hy;
            longint ax, ay, bx, by, sx, sy, lox, hix, loy, hiy;
            int n;
            r = '{1'b0, 8'd0, 32'd0, 32'd0};
            best = {65'd0, dist_limit};
            n = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
            for (int i = 0; i < n; i++)
            begin
                ax = $signed(start_x[i]); ay = $signed(start_y[i]);
                bx = $signed(end_x[i]);   by = $signed(end_y[i]);
                sx = bx - ax; sy = by - ay;
                lox = (ax < bx) ? ax : bx; hix = (ax < bx) ? bx : ax;
                loy = (ay < by) ? ay : by; hiy = (ay < by) ? by : ay;
                den = wide_t'(dx) * wide_t'(sy) - wide_t'(dy) * wide_t'(sx);
                if (den == 0)
                    continue;
                tn = wide_t'(ax - ox) * wide_t'(sy) - wide_t'(ay - oy) * wide_t'(sx);
                if (den < 0)
                begin
                    den = -den;
                    tn = -tn;
                end
                if (tn <= 0)
                    continue;
                xn = wide_t'(ox) * den + wide_t'(dx) * tn;
                yn = wide_t'(oy) * den + wide_t'(dy) * tn;
                if (xn < wide_t'(lox) * den || xn > wide_t'(hix) * den)
                    continue;
                if (yn < wide_t'(loy) * den || yn > wide_t'(hiy) * den)
                    continue;
                // round toward minus infinity
                q = xn / den;
                if (xn % den != 0 && xn < 0) q = q - 1;
                hx = q;
                q = yn / den;
                if (yn % den != 0 && yn < 0) q = q - 1;
                hy = q;
                d = (hx - wide_t'(ox)) * (hx - wide_t'(ox)) + (hy - wide_t'(oy)) * (hy - wide_t'(oy));
                if (d == 0)
                    continue;
                if (d < best)
                begin
                    best = d;
                    r = '{1'b1, i[7:0], hx[31:0], hy[31:0]};
                end
            end
            return r;
        endfunction

        function void note_command(logic f, logic [7:0] si, logic [31:0] a0, logic [31:0] a1,
                                   logic [31:0] b0, logic [31:0] b1);
            hit_result_t r;
            if (f == FUNC_LOAD)
            begin
                start_x[si] = a0; start_y[si] = a1;
                end_x[si] = b0;   end_y[si] = b1;
                loads++;
            end
            else
            begin
                r = nearest_hit($signed(a0), $signed(a1), $signed(b0), $signed(b1));
                expected_hits.push_back(r);
                queries++;
                if (r.hit) hits++;
            end
        endfunction

        function void check_result(hit_result_t got);
            hit_result_t e;
            results++;
            if (expected_hits.size() == 0)
            begin
                $error("result with no query outstanding");
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (got.hit !== e.hit)
            begin
                $error("hit: expected %0d actual %0d", e.hit, got.hit);
                errors++;
            end
            if (got.idx !== e.idx)
            begin
                $error("hit_index: expected %0d actual %0d", e.idx, got.idx);
                errors++;
            end
            if (got.x !== e.x)
            begin
                $error("hit_x: expected %h actual %h", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y)
            begin
                $error("hit_y: expected %h actual %h", e.y, got.y);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, func, done, hit, pready;
    logic [ADDR_W-1:0] seg_index, hit_index;
    logic signed [COORD_W-1:0] ax, ay, bx, by, hit_x, hit_y;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;

    hit_scoreboard sb;
    longint cycles;
    int burst_left;
    int loaded;

    nearest_ray_segment_hit_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .seg_index(seg_index), .ax(ax), .ay(ay), .bx(bx), .by(by),
        .done(done), .hit(hit), .hit_index(hit_index), .hit_x(hit_x), .hit_y(hit_y),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        sb = new();
    end

    // results last one cycle; sample mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{hit, hit_index, hit_x, hit_y});
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [63:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= (idx == REG_SEG_COUNT) ? 4'd0 : 4'd8;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_SEG_COUNT) sb.seg_count = value[8:0];
        else sb.dist_limit = value[62:0];
        @(posedge clk);
    endtask

    // drop start and hold until every query has answered
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_hits.size() != 0 || busy)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_cmd(logic f, logic [7:0] si, logic [31:0] a0, logic [31:0] a1,
                            logic [31:0] b0, logic [31:0] b1);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        func <= f; seg_index <= si; ax <= a0; ay <= a1; bx <= b0; by <= b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_command(f, si, a0, a1, b0, b1);
    endtask

    function automatic longint near_coord();
        return longint'($urandom_range(0, 2 * NEAR)) - NEAR;
    endfunction

    task automatic load_near(logic [7:0] si);
        send_cmd(FUNC_LOAD, si, 32'(near_coord()), 32'(near_coord()),
                 32'(near_coord()), 32'(near_coord()));
    endtask

    // aim a ray at a point of a loaded segment below count; some modes reverse it or run it along the segment
    task automatic aimed_query(int count);
        int k, f, mode;
        longint pax, pay, pbx, pby, px, py, ox, oy, dx, dy;
        k = $urandom_range(0, count - 1);
        pax = $signed(sb.start_x[k]); pay = $signed(sb.start_y[k]);
        pbx = $signed(sb.end_x[k]);   pby = $signed(sb.end_y[k]);
        f = $urandom_range(0, 256);
        px = pax + ((pbx - pax) * f) / 256;
        py = pay + ((pby - pay) * f) / 256;
        ox = near_coord(); oy = near_coord();
        mode = $urandom_range(0, 9);
        if (mode == 0) ox = px;
        if (mode == 1) oy = py;
        dx = px - ox; dy = py - oy;
        if (mode == 2) begin dx = -dx; dy = -dy; end
        if (mode == 3) begin dx = pbx - pax; dy = pby - pay; end
        if (mode == 4) begin dx = dx / 4; dy = dy / 4; end
        send_cmd(FUNC_QUERY, 8'($urandom), 32'(ox), 32'(oy), 32'(dx), 32'(dy));
    endtask

    task automatic random_phase(int items, int count);
        for (int n = 0; n < items; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: load_near(8'($urandom_range(0, count - 1)));
                2: send_cmd(1'($urandom), 8'($urandom), $urandom, $urandom, $urandom, $urandom);
                default: aimed_query(count);
            endcase
            if (n == items / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        cycles = 0;
        burst_left = 0;
        rst_n = 1'b0; start = 1'b0; func = FUNC_LOAD; seg_index = '0;
        ax = '0; ay = '0; bx = '0; by = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_SEG_COUNT, 64'd8);
        write_reg(REG_MAX_DIST, {1'b0, DIST_MAX});
        // horizontal, vertical, diagonal, a point, a duplicate for ties, extremes
        send_cmd(FUNC_LOAD, 8'd0, -32'sd655360, 32'sd655360, 32'sd655360, 32'sd655360);
        send_cmd(FUNC_LOAD, 8'd1, 32'sd1310720, -32'sd655360, 32'sd1310720, 32'sd655360);
        send_cmd(FUNC_LOAD, 8'd2, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536);
        send_cmd(FUNC_LOAD, 8'd3, 32'sd196608, 32'sd196608, 32'sd196608, 32'sd196608);
        send_cmd(FUNC_LOAD, 8'd4, -32'sd1966080, -32'sd655360, -32'sd1966080, 32'sd655360);
        send_cmd(FUNC_LOAD, 8'd5, -32'sd1966080, -32'sd655360, -32'sd1966080, 32'sd655360);
        send_cmd(FUNC_LOAD, 8'd6, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_cmd(FUNC_LOAD, 8'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536);       // dx zero, up
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd65536);      // dx zero, down
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0);       // right
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, -32'sd65536, 32'sd0);      // left, tie
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536);   // along diagonal
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd655360, 32'sd65536, 32'sd0);  // origin on a segment
        send_cmd(FUNC_QUERY, 8'd0, -32'sd655360, 32'sd0, 32'sd655360, 32'sd655360); // mid-span
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'h7fffffff, 32'h80000000);
        send_cmd(FUNC_QUERY, 8'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_cmd(FUNC_QUERY, 8'hff, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
        drain();

        // tight limit: only near hits count
        write_reg(REG_MAX_DIST, 64'h0000_0001_0000_0000);
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd589824, 32'sd0, 32'sd65536);
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536);
        drain();
        write_reg(REG_SEG_COUNT, 64'd0);
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536);
        drain();
        write_reg(REG_MAX_DIST, 64'd0);
        write_reg(REG_SEG_COUNT, 64'd8);
        send_cmd(FUNC_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536);
        drain();

        write_reg(REG_MAX_DIST, {1'b0, DIST_MAX});
        write_reg(REG_SEG_COUNT, 64'd12);
        for (int i = 0; i < 12; i++)
            load_near(8'(i));
        random_phase(100, 12);

        write_reg(REG_SEG_COUNT, 64'd3);
        write_reg(REG_MAX_DIST, 64'h0010_0000_0000_0000);
        random_phase(60, 3);

        // fill the whole table and scan all of it a few times
        for (int i = 0; i < MAX_SEGMENTS; i++)
            load_near(8'(i));
        drain();
        write_reg(REG_SEG_COUNT, 64'd256);
        write_reg(REG_MAX_DIST, {1'b0, DIST_MAX});
        for (int n = 0; n < 4; n++)
            aimed_query(MAX_SEGMENTS);
        drain();

        write_reg(REG_SEG_COUNT, 64'd16);
        random_phase(80, 16);
        repeat (100) @(posedge clk);

        $display("Covered %0d loads and %0d queries, %0d of them hits, %0d results checked.",
                 sb.loads, sb.queries, sb.hits, sb.results);
        if (sb.errors == 0 && sb.expected_hits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ nearest_ray_segment_hit_top.f @@
rtl/nrsh_pkg.sv
rtl/nrsh_ram.sv
rtl/nrsh_scale.sv
rtl/nearest_ray_segment_hit_top.sv
tb/tb.sv
